// ===== hdl/bchd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bchd_pkg
// Shared types, widths and event codes of the button click and hold detector.
// ----------------------------------------------------------------------------
package bchd_pkg;

   localparam int NUM_KEYS = 8;
   localparam int KEY_AW   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

   localparam int KEY_W    = 3;
   localparam int CODE_W   = 4;
   localparam int CLICK_W  = 8;
   localparam int PHASE_W  = 4;
   localparam int DB_W     = 6;
   localparam int TICK_W   = 16;
   localparam int IVL_W    = 8;
   localparam int HOLD_W   = 16;
   localparam int HTH_W    = 14;
   localparam int CTH_W    = 16;
   localparam int WIN_W    = 8;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_TH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLICK_TH    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MULTI_WIN   = 2'd3;

   localparam logic [DB_W-1:0]  DEBOUNCE_TH_RST = 6'd3;
   localparam logic [HTH_W-1:0] HOLD_TH_RST     = 14'd100;
   localparam logic [CTH_W-1:0] CLICK_TH_RST    = 16'd10;
   localparam logic [WIN_W-1:0] MULTI_WIN_RST   = 8'd30;

   // event codes
   localparam logic [CODE_W-1:0] EV_DOWN   = 4'd0;
   localparam logic [CODE_W-1:0] EV_UP     = 4'd1;
   localparam logic [CODE_W-1:0] EV_CLICK  = 4'd2;
   localparam logic [CODE_W-1:0] EV_MULTI1 = 4'd3;
   localparam logic [CODE_W-1:0] EV_MULTI5 = 4'd7;
   localparam logic [CODE_W-1:0] EV_HOLD1  = 4'd8;
   localparam logic [CODE_W-1:0] EV_HOLD2  = 4'd9;
   localparam logic [CODE_W-1:0] EV_HOLD3  = 4'd10;
   localparam logic [CODE_W-1:0] EV_LEN1   = 4'd11;
   localparam logic [CODE_W-1:0] EV_LEN2   = 4'd12;
   localparam logic [CODE_W-1:0] EV_LEN3   = 4'd13;

   // phases: idle, then event code plus one
   localparam logic [PHASE_W-1:0] PH_IDLE   = 4'd0;
   localparam logic [PHASE_W-1:0] PH_DOWN   = 4'd1;
   localparam logic [PHASE_W-1:0] PH_UP     = 4'd2;
   localparam logic [PHASE_W-1:0] PH_CLICK  = 4'd3;
   localparam logic [PHASE_W-1:0] PH_MULTI1 = 4'd4;
   localparam logic [PHASE_W-1:0] PH_MULTI5 = 4'd8;
   localparam logic [PHASE_W-1:0] PH_HOLD1  = 4'd9;
   localparam logic [PHASE_W-1:0] PH_HOLD2  = 4'd10;
   localparam logic [PHASE_W-1:0] PH_HOLD3  = 4'd11;
   localparam logic [PHASE_W-1:0] PH_LEN1   = 4'd12;
   localparam logic [PHASE_W-1:0] PH_LEN3   = 4'd14;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic               stable_level;
      logic [DB_W-1:0]    debounce_count;
      logic [TICK_W-1:0]  tick_count;
      logic [IVL_W-1:0]   interval_count;
      logic [CLICK_W-1:0] click_count;
      logic [HOLD_W-1:0]  hold_count;
   } key_state_type;

   localparam int STATE_W = $bits(key_state_type);

endpackage

// ===== hdl/bchd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bchd interfaces
// Valid/ready channels for poll ticks, events and register writes.
// ----------------------------------------------------------------------------
interface bchd_req_if;
   logic                       valid;
   logic                       ready;
   logic [bchd_pkg::KEY_W-1:0] key_index;
   logic                       pressed;

   modport source (output valid, output key_index, output pressed, input ready);
   modport sink   (input valid, input key_index, input pressed, output ready);
endinterface

interface bchd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bchd_pkg::KEY_W-1:0]   event_key;
   logic [bchd_pkg::CODE_W-1:0]  event_code;
   logic [bchd_pkg::CLICK_W-1:0] click_total;

   modport source (output valid, output event_key, output event_code,
                   output click_total, input ready);
   modport sink   (input valid, input event_key, input event_code,
                   input click_total, output ready);
endinterface

interface bchd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [bchd_pkg::CSR_IDX_W-1:0]  index;
   logic [bchd_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/bchd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bchd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bchd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/button_click_hold_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_hold_detector
// Per-key debounce, click, multi-click and long-press event detection.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one poll tick per transaction: a key index and the raw
//   pressed level of that key. rsp_chan returns zero or one event per tick:
//   the key, the event code and the click count held for that key. csr_chan
//   writes the four thresholds (debounce, hold, click, multi-click window);
//   it is always ready and should only be written while the block is idle.
//   A tick accepted on req_chan passes the compute stage register and then
//   the output register before its event shows on rsp_chan. One tick is
//   accepted per cycle while rsp_chan does not stall. Each tick does one
//   read-modify-write of its key's state word in the state RAM (read in the
//   accept cycle, written back from the compute stage); a write-back register
//   forwards the newest word so ticks for the same key can follow back to back.
//   Reset clears every key to idle through one valid bit per RAM entry (an
//   entry not yet written reads as all zero) and loads the threshold reset
//   values; no clearing pass is needed.
//   When rsp_chan stalls with an event pending, the tick in the compute
//   stage holds and req_chan.ready drops until the event is taken.
// ----------------------------------------------------------------------------
module button_click_hold_detector (
   input logic       clock,
   input logic       reset,
   bchd_req_if.sink  req_chan,
   bchd_rsp_if.source rsp_chan,
   bchd_csr_if.sink  csr_chan
);
   import bchd_pkg::*;

   // configuration registers
   logic [DB_W-1:0]  debounce_th_ff;
   logic [HTH_W-1:0] hold_th_ff;
   logic [CTH_W-1:0] click_th_ff;
   logic [WIN_W-1:0] multi_win_ff;

   // compute stage
   logic             s1_valid_ff, s1_valid_in;
   logic [KEY_W-1:0] s1_key_ff;
   logic             s1_level_ff;

   // write-back forwarding and per-entry valid bits
   logic                fwd_valid_ff;
   logic [KEY_AW-1:0]   fwd_addr_ff;
   key_state_type       fwd_data_ff;
   logic [NUM_KEYS-1:0] entry_valid_ff;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]   rsp_key_ff;
   logic [CODE_W-1:0]  rsp_code_ff;
   logic [CLICK_W-1:0] rsp_click_ff;

   logic              req_fire;
   logic              stall;
   logic              commit;
   logic              in_range;
   logic [KEY_AW-1:0] s1_addr;
   logic [KEY_AW-1:0] rd_addr;
   logic [STATE_W-1:0] rd_word;
   key_state_type     cur;
   key_state_type     nxt;
   logic              ev_fire;
   logic [CODE_W-1:0] ev_code;

   logic [HOLD_W-1:0] hold_x1, hold_x2, hold_x3, hold_x4;

   // hold stays only while an event waits and the receiver is not taking it
   assign stall    = s1_valid_ff && rsp_valid_ff && !rsp_chan.ready;
   assign req_chan.ready = !stall;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign s1_addr  = KEY_AW'(s1_key_ff);
   assign in_range = (32'(s1_key_ff) < NUM_KEYS);
   assign commit   = s1_valid_ff && !stall && in_range;

   // re-read the held key while stalled so the read data stays current
   assign rd_addr = stall ? s1_addr : KEY_AW'(req_chan.key_index);

   bchd_ram #(
      .WIDTH (STATE_W),
      .DEPTH (NUM_KEYS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (s1_addr),
      .wr_data (nxt),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   // select the newest copy of the key's state
   always_comb begin
      if (fwd_valid_ff && fwd_addr_ff == s1_addr) begin
         cur = fwd_data_ff;
      end else if (entry_valid_ff[s1_addr]) begin
         cur = key_state_type'(rd_word);
      end else begin
         cur = '0;
      end
   end

   assign hold_x1 = HOLD_W'(hold_th_ff);
   assign hold_x2 = HOLD_W'({hold_th_ff, 1'b0});
   assign hold_x3 = HOLD_W'({hold_th_ff, 1'b0}) + HOLD_W'(hold_th_ff);
   assign hold_x4 = HOLD_W'({hold_th_ff, 2'b00});

   // event logic for one tick of one key
   always_comb begin
      nxt     = cur;
      ev_fire = 1'b0;
      ev_code = EV_DOWN;

      if (cur.phase != PH_IDLE) begin
         nxt.tick_count = cur.tick_count + 1'b1;
      end

      // debounce: the count is not cleared by agreeing samples
      if (s1_level_ff != cur.stable_level) begin
         nxt.debounce_count = cur.debounce_count + 1'b1;
         if (nxt.debounce_count >= debounce_th_ff) begin
            nxt.tick_count     = '0;
            nxt.stable_level   = s1_level_ff;
            nxt.debounce_count = '0;
         end
      end

      case (cur.phase)
         PH_IDLE: begin
            if (nxt.stable_level) begin
               ev_fire = 1'b1;
               ev_code = EV_DOWN;
            end else if (cur.click_count != '0) begin
               nxt.interval_count = cur.interval_count + 1'b1;
               if (nxt.interval_count >= multi_win_ff) begin
                  nxt.interval_count = '0;
                  nxt.click_count    = '0;
                  // six or more clicks drop out without an event
                  if (cur.click_count <= CLICK_W'(EV_MULTI5 - EV_CLICK)) begin
                     ev_fire = 1'b1;
                     ev_code = EV_CLICK + CODE_W'(cur.click_count);
                  end
               end
            end
         end
         PH_DOWN: begin
            if (nxt.stable_level) begin
               if (nxt.tick_count >= TICK_W'(hold_th_ff)) begin
                  nxt.hold_count = hold_x1;
                  ev_fire = 1'b1;
                  ev_code = EV_HOLD1;
               end
            end else begin
               ev_fire = 1'b1;
               ev_code = EV_UP;
            end
         end
         PH_UP: begin
            if (nxt.stable_level) begin
               ev_fire = 1'b1;
               ev_code = EV_DOWN;
            end else if (nxt.tick_count >= click_th_ff) begin
               ev_fire = 1'b1;
               ev_code = EV_CLICK;
            end
         end
         PH_CLICK: begin
            nxt.phase          = PH_IDLE;
            nxt.interval_count = '0;
            nxt.click_count    = cur.click_count + 1'b1;
         end
         PH_HOLD1, PH_HOLD2, PH_HOLD3: begin
            if (!nxt.stable_level) begin
               ev_fire = 1'b1;
               ev_code = (cur.phase == PH_HOLD1) ? EV_LEN1 :
                         (cur.phase == PH_HOLD2) ? EV_LEN2 : EV_LEN3;
            end else begin
               nxt.hold_count = cur.hold_count + 1'b1;
               if (cur.phase == PH_HOLD1) begin
                  if (nxt.hold_count >= hold_x2) begin
                     ev_fire = 1'b1;
                     ev_code = EV_HOLD2;
                  end
               end else if (cur.phase == PH_HOLD2) begin
                  if (nxt.hold_count >= hold_x3) begin
                     ev_fire = 1'b1;
                     ev_code = EV_HOLD3;
                  end
               end else if (nxt.hold_count >= hold_x4) begin
                  // end of the long press, back to idle silently
                  nxt.phase = PH_IDLE;
               end
            end
         end
         default: begin
            if (cur.phase >= PH_MULTI1 && cur.phase <= PH_MULTI5) begin
               nxt.phase = PH_IDLE;
            end else if (cur.phase >= PH_LEN1 && cur.phase <= PH_LEN3) begin
               nxt.hold_count = '0;
               if (!nxt.stable_level) begin
                  ev_fire = 1'b1;
                  ev_code = EV_UP;
               end
            end
         end
      endcase

      if (ev_fire) begin
         nxt.phase = ev_code + 1'b1;
      end
      // the up after a hold length drops straight to idle
      if (ev_fire && cur.phase >= PH_LEN1 && cur.phase <= PH_LEN3) begin
         nxt.phase = PH_IDLE;
      end
   end

   always_comb begin
      if (stall) begin
         s1_valid_in = s1_valid_ff;
      end else begin
         s1_valid_in = req_fire;
      end
   end

   always_comb begin
      if (commit && ev_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         fwd_valid_ff   <= 1'b0;
         entry_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         debounce_th_ff <= DEBOUNCE_TH_RST;
         hold_th_ff     <= HOLD_TH_RST;
         click_th_ff    <= CLICK_TH_RST;
         multi_win_ff   <= MULTI_WIN_RST;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            fwd_valid_ff            <= 1'b1;
            entry_valid_ff[s1_addr] <= 1'b1;
         end
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.index)
               CSR_DEBOUNCE_TH: debounce_th_ff <= csr_chan.data[DB_W-1:0];
               CSR_HOLD_TH:     hold_th_ff     <= csr_chan.data[HTH_W-1:0];
               CSR_CLICK_TH:    click_th_ff    <= csr_chan.data[CTH_W-1:0];
               CSR_MULTI_WIN:   multi_win_ff   <= csr_chan.data[WIN_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (!stall) begin
         s1_key_ff   <= req_chan.key_index;
         s1_level_ff <= req_chan.pressed;
      end
      if (commit) begin
         fwd_addr_ff <= s1_addr;
         fwd_data_ff <= nxt;
      end
      if (commit && ev_fire) begin
         rsp_key_ff   <= s1_key_ff;
         rsp_code_ff  <= ev_code;
         rsp_click_ff <= cur.click_count;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.event_key   = rsp_key_ff;
   assign rsp_chan.event_code  = rsp_code_ff;
   assign rsp_chan.click_total = rsp_click_ff;

endmodule
